/* hw/rtl/pcx_rle_pkg.sv */
// ----------------------------------------------------------------------------
// pcx_rle_pkg
// Shared types and constants for the PCX 8-bit run-length line decoder.
// ----------------------------------------------------------------------------
package pcx_rle_pkg;

   localparam int MAX_DIMENSION_DEF = 8192;
   localparam int BYTE_W            = 8;
   localparam int RUN_W             = 6;
   localparam int REG_W             = 14;
   localparam int CSR_INDEX_W       = 4;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_W       = 2;
   localparam int QUEUE_CNT_W       = 3;

   localparam logic [1:0] RUN_MARK = 2'b11;

   localparam logic [REG_W-1:0] LINE_WIDTH_RESET   = REG_W'(640);
   localparam logic [REG_W-1:0] IMAGE_HEIGHT_RESET = REG_W'(480);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LINE_WIDTH   = CSR_INDEX_W'(0),
      REG_IMAGE_HEIGHT = CSR_INDEX_W'(1)
   } reg_index_type;

   // One pixel command: a value repeated count times (count never zero).
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic [RUN_W-1:0]  count;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

   typedef struct packed {
      logic                   valid;
      logic                   full;
      logic [QUEUE_CNT_W-1:0] count;
      cmd_type                cmd;
   } queue_status_type;

endpackage

/* hw/rtl/pcx_rle_front.sv */
// ----------------------------------------------------------------------------
// pcx_rle_front
// Accepts compressed bytes, splits them into run counts, run values and
// literals, and issues pixel commands to the queue.
// ----------------------------------------------------------------------------
module pcx_rle_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pcx_rle_pkg::BYTE_W-1:0] req_byte_value,
   input  logic                          queue_full,
   output pcx_rle_pkg::cmd_push_type     push
);

   logic                          awaiting_ff, awaiting_in;
   logic [pcx_rle_pkg::RUN_W-1:0] run_ff, run_in;
   logic                          accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      awaiting_in     = awaiting_ff;
      run_in          = run_ff;
      push.valid      = 1'b0;
      push.cmd.value  = req_byte_value;
      push.cmd.count  = pcx_rle_pkg::RUN_W'(1);
      if (accept) begin
         if (awaiting_ff) begin
            awaiting_in    = 1'b0;
            run_in         = '0;
            push.cmd.count = run_ff;
            push.valid     = (run_ff != '0);
         end else if (req_byte_value[7:6] == pcx_rle_pkg::RUN_MARK) begin
            awaiting_in = 1'b1;
            run_in      = req_byte_value[pcx_rle_pkg::RUN_W-1:0];
         end else begin
            push.valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         run_ff      <= '0;
      end else begin
         awaiting_ff <= awaiting_in;
         run_ff      <= run_in;
      end
   end

endmodule

/* hw/rtl/pcx_rle_queue.sv */
// ----------------------------------------------------------------------------
// pcx_rle_queue
// Short command queue between the byte front end and the pixel back end.
// ----------------------------------------------------------------------------
module pcx_rle_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  pcx_rle_pkg::cmd_push_type     push,
   input  logic                          pop,
   output pcx_rle_pkg::queue_status_type status
);

   pcx_rle_pkg::cmd_type                  entry_ff [pcx_rle_pkg::QUEUE_DEPTH];
   logic [pcx_rle_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pcx_rle_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pcx_rle_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                                  do_push, do_pop;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == pcx_rle_pkg::QUEUE_CNT_W'(pcx_rle_pkg::QUEUE_DEPTH));
   assign status.count = count_ff;
   assign status.cmd   = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/pcx_rle_back.sv */
// ----------------------------------------------------------------------------
// pcx_rle_back
// Expands pixel commands into pixels, tracks column and row, clips runs at
// the line end and drops everything once the image is complete.
// ----------------------------------------------------------------------------
module pcx_rle_back #(
   parameter int MAX_DIMENSION = pcx_rle_pkg::MAX_DIMENSION_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pcx_rle_pkg::REG_W-1:0]   line_width,
   input  logic [pcx_rle_pkg::REG_W-1:0]   image_height,
   input  pcx_rle_pkg::queue_status_type   queue,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pcx_rle_pkg::BYTE_W-1:0]  rsp_pixel,
   output logic                            rsp_last_of_input,
   output logic                            rsp_end_of_line,
   output logic                            rsp_end_of_image
);

   localparam int COL_W = $clog2(MAX_DIMENSION);
   localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
   localparam int CMP_W = (DIM_W > pcx_rle_pkg::REG_W) ? DIM_W : pcx_rle_pkg::REG_W;
   localparam logic [CMP_W-1:0] MAX_DIM = CMP_W'(MAX_DIMENSION);

   logic                          busy_ff, busy_in;
   logic [pcx_rle_pkg::BYTE_W-1:0] value_ff, value_in;
   logic [pcx_rle_pkg::RUN_W-1:0]  remain_ff, remain_in;
   logic [COL_W-1:0]              col_ff, col_in;
   logic [COL_W-1:0]              row_ff, row_in;
   logic                          done_ff, done_in;
   logic                          valid_ff, valid_in;
   logic [pcx_rle_pkg::BYTE_W-1:0] pixel_ff, pixel_in;
   logic                          last_ff, last_in;
   logic                          eol_ff, eol_in;
   logic                          eoi_ff, eoi_in;

   logic [CMP_W-1:0] width_ext, height_ext, width_clamp, height_clamp;
   logic             out_free, emit, eol, eoi, last, finishing, done_now;

   assign width_ext  = CMP_W'(line_width);
   assign height_ext = CMP_W'(image_height);

   always_comb begin
      if (width_ext == '0) begin
         width_clamp = CMP_W'(1);
      end else if (width_ext > MAX_DIM) begin
         width_clamp = MAX_DIM;
      end else begin
         width_clamp = width_ext;
      end
      if (height_ext == '0) begin
         height_clamp = CMP_W'(1);
      end else if (height_ext > MAX_DIM) begin
         height_clamp = MAX_DIM;
      end else begin
         height_clamp = height_ext;
      end
   end

   assign out_free  = !valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_free;
   assign eol       = (CMP_W'(col_ff) + CMP_W'(1)) >= width_clamp;
   assign eoi       = eol && ((CMP_W'(row_ff) + CMP_W'(1)) >= height_clamp);
   assign last      = (remain_ff == pcx_rle_pkg::RUN_W'(1)) || eol;
   assign finishing = emit && last;
   assign done_now  = done_ff || (emit && eoi);
   assign pop       = queue.valid && (!busy_ff || finishing);

   always_comb begin
      busy_in   = busy_ff;
      value_in  = value_ff;
      remain_in = remain_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      done_in   = done_now;
      valid_in  = rsp_stall ? valid_ff : 1'b0;
      pixel_in  = pixel_ff;
      last_in   = last_ff;
      eol_in    = eol_ff;
      eoi_in    = eoi_ff;

      if (emit) begin
         remain_in = remain_ff - 1'b1;
         valid_in  = 1'b1;
         pixel_in  = value_ff;
         last_in   = last;
         eol_in    = eol;
         eoi_in    = eoi;
         if (eol) begin
            col_in = '0;
            row_in = eoi ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
         if (last) begin
            busy_in = 1'b0;
         end
      end

      if (pop) begin
         busy_in   = !done_now;
         value_in  = queue.cmd.value;
         remain_in = queue.cmd.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
         done_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      remain_ff <= remain_in;
      pixel_ff  <= pixel_in;
      last_ff   <= last_in;
      eol_ff    <= eol_in;
      eoi_ff    <= eoi_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_pixel         = pixel_ff;
   assign rsp_last_of_input = last_ff;
   assign rsp_end_of_line   = eol_ff;
   assign rsp_end_of_image  = eoi_ff;

endmodule

/* hw/rtl/pcx_rle_line_decoder_unit.sv */
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder_unit
// Run-length decoder for 8-bit PCX pixel data with line and image framing.
// ----------------------------------------------------------------------------
// The front end takes one compressed byte per cycle into a four-entry command
// queue, unless the queue is full; a literal becomes one pixel, a count byte
// plus value byte become a run of up to 63 pixels. The back end emits one
// pixel per cycle from its output register unless the receiver stalls, so
// once the queue fills, long runs hold the input back while they expand.
// Runs are clipped at the line end; after the last pixel of the image
// every further byte is accepted and dropped until reset. line_width and
// image_height (indexes 0 and 1) read zero as one and saturate at
// MAX_DIMENSION; write them only while the unit is idle.
// ----------------------------------------------------------------------------
module pcx_rle_line_decoder_unit #(
   parameter int MAX_DIMENSION = pcx_rle_pkg::MAX_DIMENSION_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pcx_rle_pkg::BYTE_W-1:0]      req_byte_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pcx_rle_pkg::BYTE_W-1:0]      rsp_pixel,
   output logic                                rsp_last_of_input,
   output logic                                rsp_end_of_line,
   output logic                                rsp_end_of_image,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcx_rle_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pcx_rle_pkg::REG_W-1:0]       csr_data
);

   logic [pcx_rle_pkg::REG_W-1:0]  line_width_ff, line_width_in;
   logic [pcx_rle_pkg::REG_W-1:0]  image_height_ff, image_height_in;
   pcx_rle_pkg::cmd_push_type      push;
   pcx_rle_pkg::queue_status_type  q_stat;
   logic                           pop;

   assign csr_ready = 1'b1;

   always_comb begin
      line_width_in   = line_width_ff;
      image_height_in = image_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pcx_rle_pkg::REG_LINE_WIDTH:   line_width_in   = csr_data;
            pcx_rle_pkg::REG_IMAGE_HEIGHT: image_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= pcx_rle_pkg::LINE_WIDTH_RESET;
         image_height_ff <= pcx_rle_pkg::IMAGE_HEIGHT_RESET;
      end else begin
         line_width_ff   <= line_width_in;
         image_height_ff <= image_height_in;
      end
   end

   pcx_rle_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_value (req_byte_value),
      .queue_full     (q_stat.full),
      .push           (push)
   );

   pcx_rle_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (q_stat)
   );

   pcx_rle_back #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .line_width        (line_width_ff),
      .image_height      (image_height_ff),
      .queue             (q_stat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel         (rsp_pixel),
      .rsp_last_of_input (rsp_last_of_input),
      .rsp_end_of_line   (rsp_end_of_line),
      .rsp_end_of_image  (rsp_end_of_image)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= pcx_rle_pkg::QUEUE_CNT_W'(pcx_rle_pkg::QUEUE_DEPTH))
      else $error("command queue count out of range");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (push.valid && q_stat.full) |-> 1'b0)
      else $error("item pushed into a full queue");

   a_eoi_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_image) |-> (rsp_end_of_line && rsp_last_of_input))
      else $error("end of image without end of line and last of input");

   a_eol_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_line) |-> rsp_last_of_input)
      else $error("run not clipped at line end");

endmodule

/* test/pcx_rle_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_pixel_checker
// Watches the byte, pixel and register channels of the PCX line decoder,
// decodes every accepted byte on its own and compares each pixel it sees.
// ----------------------------------------------------------------------------
module pcx_rle_pixel_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [pcx_rle_pkg::BYTE_W-1:0]      req_byte_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [pcx_rle_pkg::BYTE_W-1:0]      rsp_pixel,
   input  logic                                rsp_last_of_input,
   input  logic                                rsp_end_of_line,
   input  logic                                rsp_end_of_image,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [pcx_rle_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pcx_rle_pkg::REG_W-1:0]       csr_data,
   output int                                  error_count,
   output int                                  pending_count
);

   typedef struct packed {
      logic [pcx_rle_pkg::BYTE_W-1:0] pixel;
      logic                           last_of_input;
      logic                           end_of_line;
      logic                           end_of_image;
   } pixel_item_type;

   pixel_item_type                 expected_pixels[$];
   pixel_item_type                 oldest;
   logic [pcx_rle_pkg::REG_W-1:0]  width_reg  = pcx_rle_pkg::LINE_WIDTH_RESET;
   logic [pcx_rle_pkg::REG_W-1:0]  height_reg = pcx_rle_pkg::IMAGE_HEIGHT_RESET;
   logic [pcx_rle_pkg::RUN_W-1:0]  run_count  = '0;
   logic                           awaiting_value = 1'b0;
   logic                           image_done = 1'b0;
   int                             column = 0;
   int                             row = 0;
   int                             errors = 0;

   function automatic int clamp_dimension(input logic [pcx_rle_pkg::REG_W-1:0] value);
      if (value == '0) return 1;
      if (int'(value) > pcx_rle_pkg::MAX_DIMENSION_DEF) return pcx_rle_pkg::MAX_DIMENSION_DEF;
      return int'(value);
   endfunction

   task automatic emit_pixel(input logic [pcx_rle_pkg::BYTE_W-1:0] value,
                             output logic line_end);
      pixel_item_type item;
      item.pixel         = value;
      item.last_of_input = 1'b0;
      item.end_of_line   = (column + 1 >= clamp_dimension(width_reg));
      item.end_of_image  = 1'b0;
      if (item.end_of_line) begin
         column = 0;
         if (row + 1 >= clamp_dimension(height_reg)) begin
            item.end_of_image = 1'b1;
            row = 0;
            image_done = 1'b1;
         end else begin
            row = row + 1;
         end
      end else begin
         column = column + 1;
      end
      expected_pixels.push_back(item);
      line_end = item.end_of_line;
   endtask

   task automatic decode_byte(input logic [pcx_rle_pkg::BYTE_W-1:0] value);
      int             remaining;
      int             first;
      logic           line_end;
      pixel_item_type tail;
      first    = expected_pixels.size();
      line_end = 1'b0;
      if (!image_done) begin
         if (awaiting_value) begin
            remaining      = int'(run_count);
            awaiting_value = 1'b0;
            run_count      = '0;
            while (remaining > 0 && !line_end) begin
               emit_pixel(value, line_end);
               remaining--;
            end
         end else if (value[7:6] == pcx_rle_pkg::RUN_MARK) begin
            run_count      = value[pcx_rle_pkg::RUN_W-1:0];
            awaiting_value = 1'b1;
         end else begin
            emit_pixel(value, line_end);
         end
         if (expected_pixels.size() > first) begin
            tail = expected_pixels.pop_back();
            tail.last_of_input = 1'b1;
            expected_pixels.push_back(tail);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pcx_rle_pkg::REG_LINE_WIDTH:   width_reg  = csr_data;
               pcx_rle_pkg::REG_IMAGE_HEIGHT: height_reg = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel %0h, none pending", rsp_pixel);
               errors++;
            end else begin
               oldest = expected_pixels.pop_front();
               if (rsp_pixel !== oldest.pixel) begin
                  $error("pixel: expected %0h, actual %0h", oldest.pixel, rsp_pixel);
                  errors++;
               end
               if (rsp_last_of_input !== oldest.last_of_input) begin
                  $error("last_of_input: expected %0b, actual %0b",
                         oldest.last_of_input, rsp_last_of_input);
                  errors++;
               end
               if (rsp_end_of_line !== oldest.end_of_line) begin
                  $error("end_of_line: expected %0b, actual %0b",
                         oldest.end_of_line, rsp_end_of_line);
                  errors++;
               end
               if (rsp_end_of_image !== oldest.end_of_image) begin
                  $error("end_of_image: expected %0b, actual %0b",
                         oldest.end_of_image, rsp_end_of_image);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) decode_byte(req_byte_value);
      end
      error_count   <= errors;
      pending_count <= expected_pixels.size();
   end

endmodule

/* test/tb_pcx_rle_line_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcx_rle_line_decoder_unit
// Drives compressed PCX byte streams into the line decoder under several
// width and height settings, with random gaps and stalls on both channels,
// and reports the verdict from the pixel checker.
// ----------------------------------------------------------------------------
module tb_pcx_rle_line_decoder_unit;

   localparam logic [pcx_rle_pkg::CSR_INDEX_W-1:0] REG_INDEX_SPARE =
      pcx_rle_pkg::CSR_INDEX_W'(15);
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 16;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [pcx_rle_pkg::BYTE_W-1:0]      req_byte_value = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [pcx_rle_pkg::BYTE_W-1:0]      rsp_pixel;
   logic                                rsp_last_of_input;
   logic                                rsp_end_of_line;
   logic                                rsp_end_of_image;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [pcx_rle_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pcx_rle_pkg::REG_W-1:0]       csr_data = '0;
   int                                  error_count;
   int                                  pending_count;

   bit                                  tx_no_idle;
   bit                                  rx_no_idle;
   int                                  holds_asked;
   int                                  holds_done;

   always #1 clock = ~clock;

   pcx_rle_line_decoder_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_value    (req_byte_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel         (rsp_pixel),
      .rsp_last_of_input (rsp_last_of_input),
      .rsp_end_of_line   (rsp_end_of_line),
      .rsp_end_of_image  (rsp_end_of_image),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   pcx_rle_pixel_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_value    (req_byte_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel         (rsp_pixel),
      .rsp_last_of_input (rsp_last_of_input),
      .rsp_end_of_line   (rsp_end_of_line),
      .rsp_end_of_image  (rsp_end_of_image),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // pixel receiver
   initial begin
      int rx_gap;
      forever begin
         if (holds_asked != holds_done) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
         rx_gap = rx_no_idle ? 0 : $urandom_range(0, 11);
         if (rx_gap > 0) begin
            rsp_stall = 1'b1;
            repeat (rx_gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic send_byte(input logic [pcx_rle_pkg::BYTE_W-1:0] value);
      int gap;
      gap = tx_no_idle ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap > 0) begin
         req_valid      = 1'b0;
         req_byte_value = pcx_rle_pkg::BYTE_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_byte_value = value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [pcx_rle_pkg::CSR_INDEX_W-1:0] index,
                            input logic [pcx_rle_pkg::REG_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // mostly literals and count/value pairs; short runs dominate
   task automatic random_stream(input int n_items);
      int                            sent;
      int                            pick;
      logic [pcx_rle_pkg::RUN_W-1:0] count;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_byte(pcx_rle_pkg::BYTE_W'($urandom_range(0, 8'hBF)));
            sent++;
         end else if (pick < 92) begin
            count = ($urandom_range(0, 3) == 0) ?
                    pcx_rle_pkg::RUN_W'($urandom_range(0, 63)) :
                    pcx_rle_pkg::RUN_W'($urandom_range(0, 8));
            send_byte({pcx_rle_pkg::RUN_MARK, count});
            send_byte(pcx_rle_pkg::BYTE_W'($urandom_range(0, 255)));
            sent += 2;
         end else begin
            send_byte(pcx_rle_pkg::BYTE_W'($urandom_range(0, 255)));
            sent++;
         end
      end
      // two literals leave no run count pending
      send_byte(8'h01);
      send_byte(8'h02);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // reset geometry 640 x 480
      send_byte(8'h00);
      send_byte(8'hBF);
      send_byte(8'h3F);
      send_byte(8'h80);
      send_byte(8'hC0);
      send_byte(8'h12);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hC1);
      send_byte(8'hC0);
      send_byte(8'hC2);
      send_byte(8'h55);
      send_byte(8'h40);
      wait_drained();

      // zero width reads as one, oversize height saturates
      write_reg(pcx_rle_pkg::REG_LINE_WIDTH, '0);
      write_reg(pcx_rle_pkg::REG_IMAGE_HEIGHT, 14'h3FFF);
      write_reg(REG_INDEX_SPARE, 14'h0002);
      send_byte(8'h7E);
      send_byte(8'hC5);
      send_byte(8'h33);
      send_byte(8'hC0);
      send_byte(8'h01);
      wait_drained();

      write_reg(pcx_rle_pkg::REG_LINE_WIDTH, 14'd8192);
      send_byte(8'hFF);
      send_byte(8'hA5);
      wait_drained();
      write_reg(pcx_rle_pkg::REG_LINE_WIDTH, 14'h3FFF);
      send_byte(8'hFF);
      send_byte(8'h5A);
      wait_drained();
      // column already past the new width
      write_reg(pcx_rle_pkg::REG_LINE_WIDTH, 14'd7);
      send_byte(8'h11);
      wait_drained();

      write_reg(pcx_rle_pkg::REG_LINE_WIDTH, 14'd3);
      write_reg(pcx_rle_pkg::REG_IMAGE_HEIGHT, 14'd8192);
      random_stream(50);
      wait_drained();

      write_reg(pcx_rle_pkg::REG_LINE_WIDTH, 14'd1);
      write_reg(pcx_rle_pkg::REG_IMAGE_HEIGHT, 14'd5000);
      tx_no_idle = 1'b1;
      rx_no_idle = 1'b1;
      random_stream(50);
      wait_drained();

      // receiver holds off while bytes keep coming
      write_reg(pcx_rle_pkg::REG_LINE_WIDTH, 14'd64);
      rx_no_idle = 1'b0;
      holds_asked++;
      random_stream(50);
      wait_drained();

      write_reg(pcx_rle_pkg::REG_LINE_WIDTH, pcx_rle_pkg::REG_W'($urandom_range(2, 40)));
      tx_no_idle = 1'b0;
      rx_no_idle = 1'b1;
      random_stream(25);
      wait_drained();
      random_stream(25);
      wait_drained();

      write_reg(pcx_rle_pkg::REG_LINE_WIDTH, 14'h3FFF);
      write_reg(pcx_rle_pkg::REG_IMAGE_HEIGHT, 14'h3FFF);
      rx_no_idle = 1'b0;
      random_stream(20);
      wait_drained();

      // zero height: the next line end closes the image, later bytes dropped
      write_reg(pcx_rle_pkg::REG_LINE_WIDTH, 14'd4);
      write_reg(pcx_rle_pkg::REG_IMAGE_HEIGHT, '0);
      send_byte(8'hC9);
      send_byte(8'h77);
      send_byte(8'hFF);
      send_byte(8'h30);
      send_byte(8'h05);
      send_byte(8'hC3);
      wait_drained();

      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
